// ===== rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 31;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned TDATA_W = 40;   // code_point + seq_bytes, padded to bytes

    // Lead byte classification masks, longest sequence first
    localparam logic [BYTE_W-1:0] LEAD6_MASK = 8'hFC;
    localparam logic [BYTE_W-1:0] LEAD5_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hC0;

    // Payload masks of the lead byte
    localparam logic [BYTE_W-1:0] PAY6_MASK = 8'h01;
    localparam logic [BYTE_W-1:0] PAY5_MASK = 8'h03;
    localparam logic [BYTE_W-1:0] PAY4_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] PAY3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] PAY2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'h3F;

    // Sequence lengths
    localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;
    localparam logic [LEN_W-1:0] LEN_5 = 3'd5;
    localparam logic [LEN_W-1:0] LEN_6 = 3'd6;

    // Decode mode register values
    localparam logic MODE_UTF8  = 1'b0;
    localparam logic MODE_ASCII = 1'b1;

    // Open sequence state
    typedef struct packed {
        logic [LEN_W-1:0] remaining;
        logic [CP_W-1:0]  accum;
        logic [LEN_W-1:0] seq_len;
    } seq_state_t;

    // One decoded character
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_bytes;
        logic             truncated;
        logic             last_char;
    } char_result_t;

endpackage

// ===== rtl/utf8d_step.sv =====
// ----------------------------------------------------------------------------
// utf8d_step
// Combinational decode of one byte against the open sequence state.
// ----------------------------------------------------------------------------
module utf8d_step
(
    input  utf8d_pkg::seq_state_t        state,
    input  logic [utf8d_pkg::BYTE_W-1:0] text_byte,
    input  logic                         end_of_text,
    input  logic                         decode_mode,
    output utf8d_pkg::seq_state_t        state_next,
    output logic                         emit,
    output utf8d_pkg::char_result_t      result
);

    logic [utf8d_pkg::LEN_W-1:0]  lead_len;
    logic [utf8d_pkg::BYTE_W-1:0] lead_payload;
    logic [utf8d_pkg::CP_W-1:0]   accum_shift;
    logic [utf8d_pkg::LEN_W-1:0]  remaining_dec;

    // Lead byte classification, priority on the longest form
    always_comb
    begin
        if ((text_byte & utf8d_pkg::LEAD6_MASK) == utf8d_pkg::LEAD6_MASK)
        begin
            lead_len     = utf8d_pkg::LEN_6;
            lead_payload = text_byte & utf8d_pkg::PAY6_MASK;
        end
        else if ((text_byte & utf8d_pkg::LEAD5_MASK) == utf8d_pkg::LEAD5_MASK)
        begin
            lead_len     = utf8d_pkg::LEN_5;
            lead_payload = text_byte & utf8d_pkg::PAY5_MASK;
        end
        else if ((text_byte & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_MASK)
        begin
            lead_len     = utf8d_pkg::LEN_4;
            lead_payload = text_byte & utf8d_pkg::PAY4_MASK;
        end
        else if ((text_byte & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_MASK)
        begin
            lead_len     = utf8d_pkg::LEN_3;
            lead_payload = text_byte & utf8d_pkg::PAY3_MASK;
        end
        else if ((text_byte & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_MASK)
        begin
            lead_len     = utf8d_pkg::LEN_2;
            lead_payload = text_byte & utf8d_pkg::PAY2_MASK;
        end
        else
        begin
            lead_len     = utf8d_pkg::LEN_1;
            lead_payload = text_byte;
        end
    end

    // Continuation: append six bits, drop bits above the code point width
    assign accum_shift   = {state.accum[utf8d_pkg::CP_W-7:0],
                            text_byte[5:0] & utf8d_pkg::CONT_MASK[5:0]};
    assign remaining_dec = state.remaining - 3'd1;

    // Sequence update and result selection
    always_comb
    begin
        state_next = '0;
        emit       = 1'b0;
        result     = '0;
        result.last_char = end_of_text;

        if (decode_mode == utf8d_pkg::MODE_ASCII)
        begin
            // Open sequence is dropped, byte passes as one character
            emit              = 1'b1;
            result.code_point = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, text_byte};
            result.seq_bytes  = utf8d_pkg::LEN_1;
        end
        else if (state.remaining == '0)
        begin
            result.code_point = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, lead_payload};
            result.seq_bytes  = utf8d_pkg::LEN_1;
            if (lead_len == utf8d_pkg::LEN_1)
            begin
                emit = 1'b1;
            end
            else if (end_of_text)
            begin
                // Text ends on a lead byte
                emit             = 1'b1;
                result.truncated = 1'b1;
            end
            else
            begin
                state_next.accum     = result.code_point;
                state_next.seq_len   = lead_len;
                state_next.remaining = lead_len - 3'd1;
            end
        end
        else
        begin
            result.code_point = accum_shift;
            if (remaining_dec == '0)
            begin
                emit             = 1'b1;
                result.seq_bytes = state.seq_len;
            end
            else if (end_of_text)
            begin
                // Partial value, not shifted for the missing bytes
                emit             = 1'b1;
                result.seq_bytes = state.seq_len - remaining_dec;
                result.truncated = 1'b1;
            end
            else
            begin
                state_next.accum     = accum_shift;
                state_next.seq_len   = state.seq_len;
                state_next.remaining = remaining_dec;
            end
        end
    end

endmodule

// ===== rtl/utf8d_out_stage.sv =====
// ----------------------------------------------------------------------------
// utf8d_out_stage
// Result register for the output stream; refills while being drained.
// ----------------------------------------------------------------------------
module utf8d_out_stage
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  utf8d_pkg::char_result_t load_data,
    output logic                    can_load,
    output logic                    out_valid,
    input  logic                    out_ready,
    output utf8d_pkg::char_result_t out_data
);

    logic                    valid_reg;
    logic                    valid_next;
    utf8d_pkg::char_result_t data_reg;

    // Free when empty or when the held result leaves this cycle
    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 (six-byte form) or ASCII decoder, one code point per
// completed character.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake              Contents
//  s_axis    in   s_axis_tvalid/tready   tdata text_byte, tlast end_of_text
//  m_axis    out  m_axis_tvalid/tready   tdata code_point, seq_bytes;
//                                        tuser truncated; tlast last_char
//  cfg       in   cfg_valid/cfg_ready    cfg_data decode_mode
//
//  One byte per cycle while s_axis_tready is high; a result appears in the
//  cycle after the byte that completes a character. Bytes inside a sequence
//  give no result. The single result register sets the rate: a byte is taken
//  whenever that register is empty or is being drained in the same cycle.
//  Reset clears the open sequence, the result valid flag and decode_mode.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [30:0] code_point, [33:31] seq_bytes, rest zero
    output logic        m_axis_tuser,   // [0] truncated
    output logic        m_axis_tlast,   // last_char

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data        // decode_mode
);

    utf8d_pkg::seq_state_t   seq_reg;
    utf8d_pkg::seq_state_t   seq_next;
    utf8d_pkg::seq_state_t   step_state;
    utf8d_pkg::char_result_t step_result;
    utf8d_pkg::char_result_t out_data;
    logic                    mode_reg;
    logic                    step_emit;
    logic                    can_load;
    logic                    accept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    // Decode mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= utf8d_pkg::MODE_UTF8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    utf8d_step u_step
    (
        .state       (seq_reg),
        .text_byte   (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .decode_mode (mode_reg),
        .state_next  (step_state),
        .emit        (step_emit),
        .result      (step_result)
    );

    // Sequence state advances only on an accepted byte
    assign seq_next = accept ? step_state : seq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= '0;
        end
        else
        begin
            seq_reg <= seq_next;
        end
    end

    utf8d_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && step_emit),
        .load_data (step_result),
        .can_load  (can_load),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    // Output packing
    assign m_axis_tdata = {6'd0, out_data.seq_bytes, out_data.code_point};
    assign m_axis_tuser = out_data.truncated;
    assign m_axis_tlast = out_data.last_char;

endmodule

// ===== rtl/utf8d_checker.sv =====
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // An empty result register never stalls the input
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // Character length stays in range
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[33:31] != 3'd0 && m_axis_tdata[33:31] != 3'd7
                          && m_axis_tdata[39:34] == 6'd0)
        else $error("seq_bytes out of range");

    // A truncated character is always the last of the text and is short
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[33:31] != 3'd6)
        else $error("truncated character not at end of text");

    // A one-byte character fits in a byte
    a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[33:31] == 3'd1 |-> m_axis_tdata[30:8] == 23'd0)
        else $error("one-byte character wider than a byte");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (.*);
